// ----- design/bmmc_pkg.sv -----
package bmmc_pkg;

    localparam int RAM_BANK_BYTES    = 8192;
    localparam int ROM_BANK_BYTES    = 16384;
    localparam int RAM_BANKS_DEFAULT = 4;

    localparam int RAM_OFS_W  = $clog2(RAM_BANK_BYTES);
    localparam int ROM_OFS_W  = $clog2(ROM_BANK_BYTES);
    localparam int ROM_BANK_W = 7;
    localparam int ROM_ADDR_W = ROM_BANK_W + ROM_OFS_W;
    localparam int CART_IDX_W = 2 + RAM_OFS_W;

    // video, work and the 0xFExx/0xFFxx page share one array
    localparam int SYS_PAGE_BYTES = 512;
    localparam int SYS_DEPTH      = 2 * RAM_BANK_BYTES + SYS_PAGE_BYTES;
    localparam int SYS_IDX_W      = $clog2(SYS_DEPTH);

    localparam logic [3:0] RAM_EN_KEY  = 4'hA;
    localparam logic [7:0] BYTE_FF     = 8'hFF;
    localparam logic [7:0] SPRITE_END  = 8'hA0;
    localparam logic [7:0] IRQ_EN_LOW  = 8'hFF;

    typedef enum logic [1:0] {
        BR_RAM_EN  = 2'd0,
        BR_ROM_LO  = 2'd1,
        BR_ROM_HI  = 2'd2,
        BR_MODE    = 2'd3
    } bank_reg_t;

    typedef enum logic [1:0] {
        SRC_REG  = 2'd0,
        SRC_SYS  = 2'd1,
        SRC_CART = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic        func;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } bus_req_t;

    typedef struct packed {
        logic [7:0]            read_data;
        logic                  rom_fetch;
        logic [ROM_ADDR_W-1:0] rom_address;
    } bus_rsp_t;

    typedef struct packed {
        logic                  sys_we;
        logic                  sys_re;
        logic [SYS_IDX_W-1:0]  sys_idx;
        logic                  cart_we;
        logic                  cart_re;
        logic [CART_IDX_W-1:0] cart_idx;
        logic [7:0]            wdata;
        rd_src_t               src;
        logic [7:0]            reg_byte;
        logic                  rom_fetch;
        logic [ROM_ADDR_W-1:0] rom_address;
    } mem_req_t;

endpackage

// ----- design/bmmc_bank_regs.sv -----
module bmmc_bank_regs #(
    parameter int RAM_BANKS = bmmc_pkg::RAM_BANKS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  bmmc_pkg::bus_req_t  req,
    output bmmc_pkg::mem_req_t  mreq
);

    logic [bmmc_pkg::ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [1:0]                      ram_bank_reg, ram_bank_next;
    logic                            ram_en_reg, ram_en_next;
    logic                            mode_reg, mode_next;
    logic [7:0]                      irq_en_reg, irq_en_next;

    logic [15:0] addr;
    logic [7:0]  wd;
    logic        wr;
    logic [1:0]  bank_mod;
    logic [4:0]  rom_lo;

    assign addr = req.bus_address;
    assign wd   = req.write_data;
    assign wr   = req.func;

    // bank number folded into the populated banks
    always_comb begin
        unique case (ram_bank_reg)
            2'd0:    bank_mod = 2'd0;
            2'd1:    bank_mod = 2'(1 % RAM_BANKS);
            2'd2:    bank_mod = 2'(2 % RAM_BANKS);
            default: bank_mod = 2'(3 % RAM_BANKS);
        endcase
    end

    assign rom_lo = (wd[4:0] == 5'd0) ? 5'd1 : wd[4:0];

    always_comb begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        ram_en_next   = ram_en_reg;
        mode_next     = mode_reg;
        irq_en_next   = irq_en_reg;
        if (accept && wr && !addr[15]) begin
            unique case (bmmc_pkg::bank_reg_t'(addr[14:13]))
                bmmc_pkg::BR_RAM_EN: ram_en_next = (wd[3:0] == bmmc_pkg::RAM_EN_KEY);
                bmmc_pkg::BR_ROM_LO: rom_bank_next = {rom_bank_reg[6:5], rom_lo};
                bmmc_pkg::BR_ROM_HI: begin
                    if (!mode_reg) begin
                        rom_bank_next = {wd[1:0], rom_bank_reg[4:0]};
                    end else begin
                        ram_bank_next = wd[1:0];
                    end
                end
                bmmc_pkg::BR_MODE:   mode_next = wd[0];
                default:             mode_next = mode_reg;
            endcase
        end
        if (accept && wr && (addr == 16'hFFFF)) begin
            irq_en_next = wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg <= 7'd1;
            ram_bank_reg <= 2'd0;
            ram_en_reg   <= 1'b0;
            mode_reg     <= 1'b0;
            irq_en_reg   <= 8'h00;
        end else begin
            rom_bank_reg <= rom_bank_next;
            ram_bank_reg <= ram_bank_next;
            ram_en_reg   <= ram_en_next;
            mode_reg     <= mode_next;
            irq_en_reg   <= irq_en_next;
        end
    end

    // address decode of the memory map
    always_comb begin
        mreq             = '0;
        mreq.src         = bmmc_pkg::SRC_REG;
        mreq.reg_byte    = 8'h00;
        mreq.wdata       = wd;
        mreq.cart_idx    = {bank_mod, addr[12:0]};
        if (!addr[15]) begin
            if (!wr) begin
                mreq.rom_fetch = 1'b1;
                if (!addr[14]) begin
                    mreq.rom_address = {{bmmc_pkg::ROM_BANK_W{1'b0}},
                                        addr[bmmc_pkg::ROM_OFS_W-1:0]};
                end else begin
                    mreq.rom_address = {rom_bank_reg, addr[bmmc_pkg::ROM_OFS_W-1:0]};
                end
            end
        end else if (addr[14:13] == 2'b00) begin
            mreq.sys_idx = {2'b00, addr[12:0]};
            mreq.sys_we  = wr;
            mreq.sys_re  = !wr;
            mreq.src     = wr ? bmmc_pkg::SRC_REG : bmmc_pkg::SRC_SYS;
        end else if (addr[14:13] == 2'b01) begin
            if (ram_en_reg) begin
                mreq.cart_we = wr;
                mreq.cart_re = !wr;
                mreq.src     = wr ? bmmc_pkg::SRC_REG : bmmc_pkg::SRC_CART;
            end else if (!wr) begin
                mreq.reg_byte = bmmc_pkg::BYTE_FF;
            end
        end else if (addr[15:9] != 7'h7F) begin
            // work ram and its echo
            mreq.sys_idx = {2'b01, addr[12:0]};
            mreq.sys_we  = wr;
            mreq.sys_re  = !wr;
            mreq.src     = wr ? bmmc_pkg::SRC_REG : bmmc_pkg::SRC_SYS;
        end else if (!addr[8] && (addr[7:0] >= bmmc_pkg::SPRITE_END)) begin
            // unusable region
            if (!wr) begin
                mreq.reg_byte = bmmc_pkg::BYTE_FF;
            end
        end else if (addr[8] && (addr[7:0] == bmmc_pkg::IRQ_EN_LOW)) begin
            if (!wr) begin
                mreq.reg_byte = irq_en_reg;
            end
        end else begin
            mreq.sys_idx = {2'b10, 4'b0000, addr[8:0]};
            mreq.sys_we  = wr;
            mreq.sys_re  = !wr;
            mreq.src     = wr ? bmmc_pkg::SRC_REG : bmmc_pkg::SRC_SYS;
        end
    end

    a_rom_bank_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (rom_bank_reg[4:0] != 5'd0))
        else $error("rom bank low bits are zero");

endmodule

// ----- design/bmmc_store.sv -----
module bmmc_store #(
    parameter int RAM_BANKS = bmmc_pkg::RAM_BANKS_DEFAULT
) (
    input  logic                aclk,
    input  logic                accept,
    input  bmmc_pkg::mem_req_t  mreq,
    output bmmc_pkg::bus_rsp_t  rsp
);

    localparam int CART_DEPTH = RAM_BANKS * bmmc_pkg::RAM_BANK_BYTES;
    localparam int CART_AW    = $clog2(CART_DEPTH);

    logic [7:0] sys_mem  [bmmc_pkg::SYS_DEPTH];
    logic [7:0] cart_mem [CART_DEPTH];

    logic [7:0]                      sys_q_reg;
    logic [7:0]                      cart_q_reg;
    bmmc_pkg::rd_src_t               src_reg;
    logic [7:0]                      byte_reg;
    logic                            fetch_reg;
    logic [bmmc_pkg::ROM_ADDR_W-1:0] rom_addr_reg;

    logic [CART_AW-1:0] cart_addr;

    assign cart_addr = mreq.cart_idx[CART_AW-1:0];

    always_ff @(posedge aclk) begin
        if (accept && mreq.sys_we) begin
            sys_mem[mreq.sys_idx] <= mreq.wdata;
        end
        if (accept && mreq.sys_re) begin
            sys_q_reg <= sys_mem[mreq.sys_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && mreq.cart_we) begin
            cart_mem[cart_addr] <= mreq.wdata;
        end
        if (accept && mreq.cart_re) begin
            cart_q_reg <= cart_mem[cart_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            src_reg      <= mreq.src;
            byte_reg     <= mreq.reg_byte;
            fetch_reg    <= mreq.rom_fetch;
            rom_addr_reg <= mreq.rom_address;
        end
    end

    always_comb begin
        rsp.rom_fetch   = fetch_reg;
        rsp.rom_address = rom_addr_reg;
        unique case (src_reg)
            bmmc_pkg::SRC_SYS:  rsp.read_data = sys_q_reg;
            bmmc_pkg::SRC_CART: rsp.read_data = cart_q_reg;
            default:            rsp.read_data = byte_reg;
        endcase
    end

endmodule

// ----- design/banked_memory_map_controller_unit.sv -----
// bank controller and internal memories for a cartridge-style 16-bit address map
//
// s_ channel: one bus request per transfer (func 0 read / 1 write, bus_address,
// write_data). m_ channel: exactly one response per request, in order
// (read_data, rom_fetch, rom_address). writes answer with all zero fields.
// reads of 0x0000-0x7FFF return no data but a mapped external rom address.
//
// the request is decoded and the single memory port of the addressed array is
// read or written at the accept edge, and the response is valid in the following
// cycle from the registered read data.
// throughput is one request per cycle as long as m_ready stays high.
//
// while a response waits with m_ready low, s_ready is low and nothing moves;
// the response holds steady until taken.
//
// synchronous reset (aresetn low) sets rom bank 1, ram bank 0, cartridge ram
// disabled, rom mode, interrupt-enable byte 0 and drops m_valid. ram contents
// are not cleared and are undefined until written.
module banked_memory_map_controller_unit #(
    parameter int RAM_BANKS = bmmc_pkg::RAM_BANKS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bmmc_pkg::bus_req_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output bmmc_pkg::bus_rsp_t  m_payload
);

    logic               m_valid_reg, m_valid_next;
    logic               accept;
    bmmc_pkg::mem_req_t mreq;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    bmmc_bank_regs #(
        .RAM_BANKS (RAM_BANKS)
    ) u_bank_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .req     (s_payload),
        .mreq    (mreq)
    );

    bmmc_store #(
        .RAM_BANKS (RAM_BANKS)
    ) u_store (
        .aclk   (aclk),
        .accept (accept),
        .mreq   (mreq),
        .rsp    (m_payload)
    );

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request taken while response stalled");

    a_accept_gives_rsp: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no response");

    a_fetch_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.rom_fetch) |-> (m_payload.read_data == 8'h00))
        else $error("rom fetch carries read data");

    a_addr_only_on_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.rom_fetch) |-> (m_payload.rom_address == '0))
        else $error("rom address without rom fetch");

endmodule
